FILE: src/pmsb_pkg.sv
// ----------------------------------------------------------------------------
// pmsb_pkg: shared codes for the page mode sprite blit unit
// Request modes, control register indexes and control port widths.
// ----------------------------------------------------------------------------
package pmsb_pkg;

   // control port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // control register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_X_OFFSET    = 2'd0;
   localparam logic [1:0] REG_Y_OFFSET    = 2'd1;
   localparam logic [1:0] REG_IMAGE_WIDTH = 2'd2;
   localparam logic [1:0] REG_IMAGE_PAGES = 2'd3;

   // request modes
   localparam logic [1:0] MODE_BLIT  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // pixel rows in one store page
   localparam int PAGE_ROWS = 8;

endpackage

FILE: src/pmsb_ram.sv
// ----------------------------------------------------------------------------
// pmsb_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pmsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: src/page_mode_sprite_blit_unit.sv
// ----------------------------------------------------------------------------
// page_mode_sprite_blit_unit: monochrome page frame store with byte blitter
// Blit: a fully clipped byte is dropped; else each visible page, the top one and
// any spill into the next, gets a read-modify-write through the single RAM.
// Read: RD_TOP, then RESP waits for a free result register; write: WRITE state.
// Reset: clears the store with one entry a cycle, all 2**(PW+CW) entries (1024 at
// the default size); requests are not taken meanwhile, control writes are.
// ----------------------------------------------------------------------------
module page_mode_sprite_blit_unit #(
   parameter int PAGES   = 8,
   parameter int COLUMNS = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic [4:0]                        req_image_row,
   input  logic [7:0]                        req_image_col,
   input  logic [7:0]                        req_image_byte,
   input  logic [2:0]                        req_page,
   input  logic [6:0]                        req_column,
   input  logic [7:0]                        req_value,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_read_data,
   // control port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pmsb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pmsb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pmsb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   import pmsb_pkg::*;

   localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int CW    = $clog2(COLUMNS);
   localparam int AW    = PW + CW;
   localparam int DEPTH = 1 << AW;

   localparam logic [2:0] ST_CLEAR    = 3'd0;
   localparam logic [2:0] ST_IDLE     = 3'd1;
   localparam logic [2:0] ST_RD_TOP   = 3'd2;
   localparam logic [2:0] ST_WR_TOP   = 3'd3;
   localparam logic [2:0] ST_RD_SPILL = 3'd4;
   localparam logic [2:0] ST_WR_SPILL = 3'd5;
   localparam logic [2:0] ST_RESP     = 3'd6;
   localparam logic [2:0] ST_WRITE    = 3'd7;

   // control registers
   logic signed [8:0] x_offset_ff, x_offset_in;
   logic signed [8:0] y_offset_ff, y_offset_in;
   logic [7:0]        image_width_ff, image_width_in;
   logic [4:0]        image_pages_ff, image_pages_in;

   // sequencer
   logic [2:0]        state_ff, state_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [1:0]        mode_ff, mode_in;
   logic [7:0]        byte_ff, byte_in;
   logic [2:0]        shift_ff, shift_in;
   logic [PW-1:0]     pg_top_ff, pg_top_in;
   logic [PW-1:0]     pg_spill_ff, pg_spill_in;
   logic [CW-1:0]     col_ff, col_in;
   logic              top_ok_ff, top_ok_in;
   logic              spill_ok_ff, spill_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_read_data_ff, rsp_read_data_in;

   // request decode
   logic signed [9:0]  sx;
   logic signed [10:0] py;
   logic [7:0]         pg_top;
   logic [7:0]         pg_spill;
   logic               sx_ok;
   logic               blit_ok;
   logic               top_ok;
   logic               spill_ok;
   logic               rw_ok;
   logic [15:0]        shifted;

   // RAM port
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [7:0]         ram_wdata;
   logic [AW-1:0]      ram_raddr;
   logic [7:0]         ram_rdata;

   logic               csr_write;

   // control port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      x_offset_in    = x_offset_ff;
      y_offset_in    = y_offset_ff;
      image_width_in = image_width_ff;
      image_pages_in = image_pages_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_X_OFFSET:    x_offset_in    = csr_pwdata[8:0];
            REG_Y_OFFSET:    y_offset_in    = csr_pwdata[8:0];
            REG_IMAGE_WIDTH: image_width_in = csr_pwdata[7:0];
            REG_IMAGE_PAGES: image_pages_in = csr_pwdata[4:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_X_OFFSET:    csr_prdata = {23'd0, x_offset_ff};
         REG_Y_OFFSET:    csr_prdata = {23'd0, y_offset_ff};
         REG_IMAGE_WIDTH: csr_prdata = {24'd0, image_width_ff};
         REG_IMAGE_PAGES: csr_prdata = {27'd0, image_pages_ff};
      endcase
   end

   // screen position of the blitted byte; page is a floor divide by 8
   always_comb begin
      sx       = 10'(x_offset_ff) + $signed({2'b00, req_image_col});
      py       = 11'(y_offset_ff) + $signed({3'b000, req_image_row, 3'b000});
      pg_top   = py[10:3];
      pg_spill = pg_top + 8'd1;
      sx_ok    = !sx[9] && ({1'b0, sx[8:0]} < 10'(COLUMNS));
      blit_ok  = (req_image_row < image_pages_ff) && (req_image_col < image_width_ff)
                 && sx_ok;
      top_ok   = blit_ok && !pg_top[7] && (pg_top < 8'(PAGES));
      spill_ok = blit_ok && (py[2:0] != 3'd0) && !pg_spill[7]
                 && (pg_spill < 8'(PAGES));
      rw_ok    = ({2'b00, req_page} < 5'(PAGES)) && ({2'b00, req_column} < 9'(COLUMNS));
   end

   assign shifted = {8'd0, byte_ff} << shift_ff;

   // sequencer
   always_comb begin
      state_in         = state_ff;
      clr_addr_in      = clr_addr_ff;
      mode_in          = mode_ff;
      byte_in          = byte_ff;
      shift_in         = shift_ff;
      pg_top_in        = pg_top_ff;
      pg_spill_in      = pg_spill_ff;
      col_in           = col_ff;
      top_ok_in        = top_ok_ff;
      spill_ok_in      = spill_ok_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_read_data_in = rsp_read_data_ff;
      ram_we           = 1'b0;
      ram_waddr        = {pg_top_ff, col_ff};
      ram_wdata        = byte_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            ram_wdata   = 8'd0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_mode;
               if (req_mode == MODE_BLIT) begin
                  byte_in     = req_image_byte;
                  shift_in    = py[2:0];
                  pg_top_in   = PW'(pg_top[6:0]);
                  pg_spill_in = PW'(pg_spill[6:0]);
                  col_in      = CW'(sx[8:0]);
                  top_ok_in   = top_ok;
                  spill_ok_in = spill_ok;
               end else begin
                  byte_in     = req_value;
                  shift_in    = 3'd0;
                  pg_top_in   = PW'(req_page);
                  pg_spill_in = PW'(req_page);
                  col_in      = CW'(req_column);
                  top_ok_in   = rw_ok;
                  spill_ok_in = 1'b0;
               end
               unique case (req_mode)
                  MODE_BLIT: begin
                     if (top_ok) begin
                        state_in = ST_RD_TOP;
                     end else if (spill_ok) begin
                        state_in = ST_RD_SPILL;
                     end
                  end
                  MODE_READ:  state_in = ST_RD_TOP;
                  MODE_WRITE: state_in = ST_WRITE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_RD_TOP: begin
            state_in = (mode_ff == MODE_READ) ? ST_RESP : ST_WR_TOP;
         end
         ST_WR_TOP: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | shifted[7:0];
            state_in  = spill_ok_ff ? ST_RD_SPILL : ST_IDLE;
         end
         ST_RD_SPILL: begin
            state_in = ST_WR_SPILL;
         end
         ST_WR_SPILL: begin
            ram_we    = 1'b1;
            ram_waddr = {pg_spill_ff, col_ff};
            ram_wdata = ram_rdata | shifted[15:8];
            state_in  = ST_IDLE;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_read_data_in = top_ok_ff ? ram_rdata : 8'd0;
               state_in         = ST_IDLE;
            end
         end
         ST_WRITE: begin
            ram_we   = top_ok_ff;
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ram_raddr = {(state_ff == ST_RD_SPILL) ? pg_spill_ff : pg_top_ff, col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         x_offset_ff    <= '0;
         y_offset_ff    <= '0;
         image_width_ff <= '0;
         image_pages_ff <= '0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         rsp_valid_ff   <= rsp_valid_in;
         x_offset_ff    <= x_offset_in;
         y_offset_ff    <= y_offset_in;
         image_width_ff <= image_width_in;
         image_pages_ff <= image_pages_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      byte_ff          <= byte_in;
      shift_ff         <= shift_in;
      pg_top_ff        <= pg_top_in;
      pg_spill_ff      <= pg_spill_in;
      col_ff           <= col_in;
      top_ok_ff        <= top_ok_in;
      spill_ok_ff      <= spill_ok_in;
      rsp_read_data_ff <= rsp_read_data_in;
   end

   pmsb_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;

endmodule

FILE: src/pmsb_checker.sv
// ----------------------------------------------------------------------------
// pmsb_checker: port level checks for the sprite blit unit
// Watches the request, result and control ports over time.
// ----------------------------------------------------------------------------
module pmsb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       csr_pready
);

   import pmsb_pkg::*;

   // a stalled result keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result changed while stalled");

   // store clear runs right after reset, no requests taken
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during store clear");

   // a read keeps the block busy while the lookup runs
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_READ) |=> !req_ready)
      else $error("read request did not occupy the block");

   // a new result only leaves a busy block
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a pending read");

   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("control port stalled");

endmodule

bind page_mode_sprite_blit_unit pmsb_checker u_pmsb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data),
   .csr_pready    (csr_pready)
);
